FILE: design/crclf_pkg.sv
package crclf_pkg;

	localparam int unsigned MAX_PAYLOAD = 256;
	localparam int unsigned ADDR_W      = $clog2(MAX_PAYLOAD);
	localparam int unsigned LEN_W       = $clog2(MAX_PAYLOAD + 1);
	localparam int unsigned FLEN_W      = 9;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic ACT_LINE = 1'b0;
	localparam logic ACT_READ = 1'b1;

	localparam logic [2:0] ST_BUSY    = 3'd0;
	localparam logic [2:0] ST_GOOD    = 3'd1;
	localparam logic [2:0] ST_LEN_ERR = 3'd2;
	localparam logic [2:0] ST_CRC_ERR = 3'd3;
	localparam logic [2:0] ST_READ    = 3'd4;

	typedef enum logic [4:0] {
		PH_LEN_LO = 5'b00001,
		PH_LEN_HI = 5'b00010,
		PH_DATA   = 5'b00100,
		PH_CRC_LO = 5'b01000,
		PH_CRC_HI = 5'b10000
	} phase_t;

	typedef struct packed {
		logic       action;
		logic [7:0] line_byte;
		logic [7:0] read_index;
	} req_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [FLEN_W-1:0] frame_length;
		logic [7:0]        read_data;
		logic [31:0]       good_frames;
		logic [31:0]       length_errors;
		logic [31:0]       crc_errors;
	} rsp_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} ram_wr_t;

	typedef struct packed {
		logic              re;
		logic [ADDR_W-1:0] addr;
		logic              hit;
	} ram_rd_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

FILE: design/crclf_payload_ram.sv
module crclf_payload_ram (
	input  logic                        clk,
	input  crclf_pkg::ram_wr_t          wr,
	input  logic                        re,
	input  logic [crclf_pkg::ADDR_W-1:0] raddr,
	output logic [7:0]                  rdata
);
	import crclf_pkg::*;

	logic [7:0] mem [MAX_PAYLOAD];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: design/crclf_parser.sv
module crclf_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  crclf_pkg::req_t    req,
	output crclf_pkg::ram_wr_t wr,
	output crclf_pkg::ram_rd_t rd,
	output crclf_pkg::rsp_t    res
);
	import crclf_pkg::*;

	phase_t             phase_q, phase_n;
	logic [7:0]         len_lo_q, len_lo_n;
	logic [LEN_W-1:0]   len_q, len_n;
	logic [LEN_W-1:0]   pos_q, pos_n;
	logic [7:0]         crc_lo_q, crc_lo_n;
	logic [15:0]        crc_q, crc_n;
	logic [LEN_W-1:0]   last_good_q, last_good_n;
	logic [31:0]        good_q, good_n;
	logic [31:0]        size_err_q, size_err_n;
	logic [31:0]        crc_err_q, crc_err_n;
	logic [15:0]        full_len;
	logic [2:0]         status;
	logic [FLEN_W-1:0]  flen;

	assign full_len = {req.line_byte, len_lo_q};

	always_comb begin
		phase_n     = phase_q;
		len_lo_n    = len_lo_q;
		len_n       = len_q;
		pos_n       = pos_q;
		crc_lo_n    = crc_lo_q;
		crc_n       = crc_q;
		last_good_n = last_good_q;
		good_n      = good_q;
		size_err_n  = size_err_q;
		crc_err_n   = crc_err_q;
		status      = ST_BUSY;
		flen        = '0;
		wr.we       = 1'b0;
		wr.addr     = pos_q[ADDR_W-1:0];
		wr.data     = req.line_byte;
		rd.re       = accept && (req.action == ACT_READ);
		rd.addr     = ADDR_W'(req.read_index);
		rd.hit      = (LEN_W'(req.read_index) < last_good_q)
			&& (LEN_W'(req.read_index) < LEN_W'(MAX_PAYLOAD));
		if (req.action == ACT_READ) begin
			status = ST_READ;
		end else if (accept) begin
			unique case (phase_q)
				PH_LEN_HI: begin
					crc_n = crc_byte(crc_q, req.line_byte);
					if (full_len == 16'd0 || full_len > 16'(MAX_PAYLOAD)) begin
						size_err_n = size_err_q + 32'd1;
						status     = ST_LEN_ERR;
						phase_n    = PH_LEN_LO;
						len_lo_n   = '0;
						len_n      = '0;
						pos_n      = '0;
						crc_lo_n   = '0;
						crc_n      = CRC_INIT;
					end else begin
						len_n   = full_len[LEN_W-1:0];
						pos_n   = '0;
						phase_n = PH_DATA;
					end
				end
				PH_DATA: begin
					wr.we = pos_q < LEN_W'(MAX_PAYLOAD);
					pos_n = pos_q + LEN_W'(1);
					crc_n = crc_byte(crc_q, req.line_byte);
					if (pos_n >= len_q) begin
						phase_n = PH_CRC_LO;
					end
				end
				PH_CRC_LO: begin
					crc_lo_n = req.line_byte;
					phase_n  = PH_CRC_HI;
				end
				PH_CRC_HI: begin
					flen = FLEN_W'(len_q);
					if (crc_q == {req.line_byte, crc_lo_q}) begin
						good_n      = good_q + 32'd1;
						last_good_n = len_q;
						status      = ST_GOOD;
					end else begin
						crc_err_n = crc_err_q + 32'd1;
						status    = ST_CRC_ERR;
					end
					phase_n  = PH_LEN_LO;
					len_lo_n = '0;
					len_n    = '0;
					pos_n    = '0;
					crc_lo_n = '0;
					crc_n    = CRC_INIT;
				end
				default: begin
					len_lo_n = req.line_byte;
					len_n    = '0;
					pos_n    = '0;
					crc_lo_n = '0;
					crc_n    = crc_byte(CRC_INIT, req.line_byte);
					phase_n  = PH_LEN_HI;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_LEN_LO;
			len_lo_q    <= '0;
			len_q       <= '0;
			pos_q       <= '0;
			crc_lo_q    <= '0;
			crc_q       <= CRC_INIT;
			last_good_q <= '0;
			good_q      <= '0;
			size_err_q  <= '0;
			crc_err_q   <= '0;
		end else if (accept) begin
			phase_q     <= phase_n;
			len_lo_q    <= len_lo_n;
			len_q       <= len_n;
			pos_q       <= pos_n;
			crc_lo_q    <= crc_lo_n;
			crc_q       <= crc_n;
			last_good_q <= last_good_n;
			good_q      <= good_n;
			size_err_q  <= size_err_n;
			crc_err_q   <= crc_err_n;
		end
	end

	assign res.status        = status;
	assign res.frame_length  = flen;
	assign res.read_data     = '0;
	assign res.good_frames   = good_n;
	assign res.length_errors = size_err_n;
	assign res.crc_errors    = crc_err_n;

endmodule

FILE: design/crc16_length_frame_receiver.sv
// Receives a byte stream of frames made of a 16-bit little-endian payload length,
// 1 to 256 payload bytes and a little-endian CRC-16/MODBUS over length and payload.
// Each item is either a line byte or a read of a stored payload byte and yields
// exactly one response item: busy, frame good, length error, crc error or read
// data, with the three 32-bit wrapping frame counters as they stand after that
// item. One item is taken every cycle while responses are taken as they appear;
// with rsp_ready low the block holds two items, one in stage one and one in the
// output register, and then drops req_ready. A response is registered in stage one
// and then in the output register before it becomes valid; stage one waits for the
// registered read port of the 256-byte payload memory, and the output register
// follows it. Reads return 0 at or beyond the last good frame's length; bytes of
// a later frame overwrite the store as they arrive.
module crc16_length_frame_receiver (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  crclf_pkg::req_t   req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output crclf_pkg::rsp_t   rsp
);
	import crclf_pkg::*;

	logic    accept;
	logic    advance;
	ram_wr_t wr;
	ram_rd_t rd;
	rsp_t    res;
	logic [7:0] ram_rdata;

	logic    valid_s1;
	rsp_t    res_s1;
	logic    hit_s1;
	logic    rsp_valid_q;
	rsp_t    rsp_q;
	rsp_t    rsp_d;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || advance;
	assign accept    = req_valid && req_ready;

	crclf_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.req    (req),
		.wr     (wr),
		.rd     (rd),
		.res    (res)
	);

	crclf_payload_ram u_ram (
		.clk   (clk),
		.wr    (wr),
		.re    (rd.re),
		.raddr (rd.addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
			hit_s1 <= rd.hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_comb begin
		rsp_d           = res_s1;
		rsp_d.read_data = (res_s1.status == ST_READ && hit_s1) ? ram_rdata : 8'h00;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("stage one item dropped while blocked");

	a_read_only_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_READ |-> rsp.read_data == 8'h00)
		else $error("read data on a non-read item");

	a_good_len: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_GOOD |->
			rsp.frame_length != '0 && rsp.frame_length <= FLEN_W'(MAX_PAYLOAD))
		else $error("good frame with bad length");

endmodule

FILE: dv/crc16_length_frame_receiver_tb.sv
module crc16_length_frame_receiver_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import crclf_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned RANDOM_ITEMS = 1250;
	localparam int unsigned QUIET_ITEMS  = 150;
	localparam int unsigned DRAIN_CYCLES = 8;

	typedef enum logic [1:0] {
		FILL_NONE,
		FILL_CRC_LO,
		FILL_CRC_HI,
		FILL_CRC_BAD
	} crc_fill_t;

	typedef struct {
		req_t      rq;
		crc_fill_t fill;
		bit        typed;
		rsp_t      want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	crc16_length_frame_receiver dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	phase_t      rx_phase;
	logic [15:0] rx_len;
	logic [8:0]  rx_pos;
	logic [7:0]  rx_crc_lo;
	logic [15:0] rx_crc;
	logic [7:0]  payload_mem [MAX_PAYLOAD];
	logic [8:0]  good_len;
	logic [31:0] good_cnt;
	logic [31:0] len_err_cnt;
	logic [31:0] crc_err_cnt;

	rsp_t        rsp_due [$];
	plan_row_t   plan_rows [$];
	rsp_t        oldest;
	int unsigned errors = 0;
	int unsigned items_sent = 0;
	int unsigned rsp_checked = 0;
	int unsigned cycle_count = 0;
	int unsigned quiet_from = 32'hFFFF_FFFF;
	int unsigned gap_odds = 4;
	bit          quiet_tail = 1'b0;

	function automatic logic [15:0] crc16_modbus_step(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] v;
		v = c ^ {8'h00, b};
		repeat (8) v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
		return v;
	endfunction

	function automatic rsp_t known_rsp(input logic [2:0] st, input logic [8:0] flen,
			input logic [7:0] rd, input logic [31:0] g, input logic [31:0] l,
			input logic [31:0] c);
		rsp_t r;
		r.status        = st;
		r.frame_length  = flen;
		r.read_data     = rd;
		r.good_frames   = g;
		r.length_errors = l;
		r.crc_errors    = c;
		return r;
	endfunction

	task automatic rx_restart();
		rx_phase  = PH_LEN_LO;
		rx_len    = '0;
		rx_pos    = '0;
		rx_crc_lo = '0;
		rx_crc    = CRC_INIT;
	endtask

	task automatic frame_rx_predict(input req_t rq, output rsp_t r);
		logic [7:0] b;
		b = rq.line_byte;
		r = '0;
		r.status = ST_BUSY;
		if (rq.action == ACT_READ) begin
			r.status = ST_READ;
			if ({1'b0, rq.read_index} < good_len) begin
				r.read_data = payload_mem[rq.read_index];
			end
		end else begin
			case (rx_phase)
				PH_LEN_HI: begin
					rx_len = {b, rx_len[7:0]};
					rx_crc = crc16_modbus_step(rx_crc, b);
					if (rx_len == 16'd0 || rx_len > 16'(MAX_PAYLOAD)) begin
						len_err_cnt = len_err_cnt + 32'd1;
						r.status = ST_LEN_ERR;
						rx_restart();
					end else begin
						rx_pos = '0;
						rx_phase = PH_DATA;
					end
				end
				PH_DATA: begin
					payload_mem[rx_pos[7:0]] = b;
					rx_pos = rx_pos + 9'd1;
					rx_crc = crc16_modbus_step(rx_crc, b);
					if (16'(rx_pos) >= rx_len) begin
						rx_phase = PH_CRC_LO;
					end
				end
				PH_CRC_LO: begin
					rx_crc_lo = b;
					rx_phase = PH_CRC_HI;
				end
				PH_CRC_HI: begin
					r.frame_length = rx_len[8:0];
					if (rx_crc == {b, rx_crc_lo}) begin
						good_cnt = good_cnt + 32'd1;
						good_len = rx_len[8:0];
						r.status = ST_GOOD;
					end else begin
						crc_err_cnt = crc_err_cnt + 32'd1;
						r.status = ST_CRC_ERR;
					end
					rx_restart();
				end
				default: begin
					rx_restart();
					rx_len = {8'h00, b};
					rx_crc = crc16_modbus_step(rx_crc, b);
					rx_phase = PH_LEN_HI;
				end
			endcase
		end
		r.good_frames   = good_cnt;
		r.length_errors = len_err_cnt;
		r.crc_errors    = crc_err_cnt;
	endtask

	function automatic logic [7:0] crc_byte_for(input crc_fill_t fill);
		case (fill)
			FILL_CRC_LO:  return rx_crc[7:0];
			FILL_CRC_HI:  return rx_crc[15:8];
			FILL_CRC_BAD: return rx_crc[15:8] ^ 8'($urandom_range(1, 255));
			default:      return 8'h00;
		endcase
	endfunction

	task automatic push_item(input req_t rq, input bit typed, input rsp_t want);
		rsp_t r;
		frame_rx_predict(rq, r);
		rsp_due.push_back(typed ? want : r);
		if (!quiet_tail && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= rq;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		items_sent++;
		if (items_sent >= quiet_from) begin
			quiet_tail = 1'b1;
		end
		if (items_sent % 64 == 0) begin
			case ($urandom_range(0, 2))
				0: gap_odds = 0;
				1: gap_odds = 3;
				default: gap_odds = 10;
			endcase
		end
	endtask

	task automatic drive_line(input logic [7:0] b);
		req_t rq;
		rq.action     = ACT_LINE;
		rq.line_byte  = b;
		rq.read_index = 8'($urandom_range(0, 255));
		push_item(rq, 1'b0, '0);
	endtask

	task automatic drive_read();
		req_t rq;
		int unsigned idx;
		if ($urandom_range(0, 3) == 0 || good_len == 0) begin
			idx = $urandom_range(0, 255);
		end else begin
			idx = $urandom_range(0, good_len);
		end
		rq.action     = ACT_READ;
		rq.line_byte  = 8'($urandom_range(0, 255));
		rq.read_index = 8'(idx);
		push_item(rq, 1'b0, '0);
	endtask

	task automatic maybe_read();
		if ($urandom_range(0, 9) == 0) begin
			drive_read();
		end
	endtask

	task automatic random_frame(input int unsigned len);
		int unsigned pick;
		drive_line(8'(len));
		maybe_read();
		drive_line(8'(len >> 8));
		for (int unsigned i = 0; i < len; i++) begin
			maybe_read();
			pick = $urandom_range(0, 7);
			drive_line(pick == 0 ? 8'h00 : pick == 1 ? 8'hFF : 8'($urandom_range(0, 255)));
		end
		drive_line(crc_byte_for(FILL_CRC_LO));
		maybe_read();
		drive_line(crc_byte_for($urandom_range(0, 6) == 0 ? FILL_CRC_BAD : FILL_CRC_HI));
	endtask

	task automatic add_row(input logic act, input logic [7:0] b, input logic [7:0] idx,
			input crc_fill_t fill, input bit typed, input rsp_t want);
		plan_row_t row;
		row.rq.action     = act;
		row.rq.line_byte  = b;
		row.rq.read_index = idx;
		row.fill          = fill;
		row.typed         = typed;
		row.want          = want;
		plan_rows.push_back(row);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (rsp_due.size() == 0) begin
				errors++;
				$display("%0t: response with none outstanding, expected nothing, actual status %0d",
					$time, rsp.status);
			end else begin
				oldest = rsp_due.pop_front();
				rsp_checked++;
				check_field("status", 32'(oldest.status), 32'(rsp.status));
				check_field("frame_length", 32'(oldest.frame_length),
					32'(rsp.frame_length));
				check_field("read_data", 32'(oldest.read_data), 32'(rsp.read_data));
				check_field("good_frames", oldest.good_frames, rsp.good_frames);
				check_field("length_errors", oldest.length_errors, rsp.length_errors);
				check_field("crc_errors", oldest.crc_errors, rsp.crc_errors);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("crc16_length_frame_receiver: mismatch");
			$finish;
		end
	end

	initial begin : ready_gen
		rsp_ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (quiet_tail) begin
				rsp_ready <= 1'b1;
				@(posedge clk);
			end else begin
				rsp_ready <= 1'b1;
				repeat ($urandom_range(1, 30)) @(posedge clk);
				if (!quiet_tail) begin
					rsp_ready <= 1'b0;
					repeat ($urandom_range(1, 14)) @(posedge clk);
				end
			end
		end
	end

	initial begin : stimulus
		req_t        rq;
		int unsigned pick;
		int unsigned len;
		int unsigned frames;
		req_valid <= 1'b0;
		req <= '0;
		rx_restart();
		good_len    = '0;
		good_cnt    = '0;
		len_err_cnt = '0;
		crc_err_cnt = '0;
		frames      = 0;

		add_row(ACT_READ, 8'hA5, 8'd0,   FILL_NONE, 1, known_rsp(ST_READ, 0, 0, 0, 0, 0));
		add_row(ACT_READ, 8'h5A, 8'd255, FILL_NONE, 1, known_rsp(ST_READ, 0, 0, 0, 0, 0));
		add_row(ACT_LINE, 8'h00, 8'd0,   FILL_NONE, 1, known_rsp(ST_BUSY, 0, 0, 0, 0, 0));
		add_row(ACT_LINE, 8'h00, 8'd255, FILL_NONE, 1, known_rsp(ST_LEN_ERR, 0, 0, 0, 1, 0));
		add_row(ACT_LINE, 8'h01, 8'd0,   FILL_NONE, 1, known_rsp(ST_BUSY, 0, 0, 0, 1, 0));
		add_row(ACT_LINE, 8'h01, 8'd0,   FILL_NONE, 1, known_rsp(ST_LEN_ERR, 0, 0, 0, 2, 0));
		add_row(ACT_LINE, 8'hFF, 8'd0,   FILL_NONE, 1, known_rsp(ST_BUSY, 0, 0, 0, 2, 0));
		add_row(ACT_LINE, 8'hFF, 8'd0,   FILL_NONE, 1, known_rsp(ST_LEN_ERR, 0, 0, 0, 3, 0));
		add_row(ACT_LINE, 8'h01, 8'd0,   FILL_NONE, 0, '0);
		add_row(ACT_LINE, 8'h00, 8'd0,   FILL_NONE, 0, '0);
		add_row(ACT_LINE, 8'hFF, 8'd0,   FILL_NONE, 0, '0);
		add_row(ACT_LINE, 8'h00, 8'd0,   FILL_CRC_LO, 0, '0);
		add_row(ACT_LINE, 8'h00, 8'd0,   FILL_CRC_HI, 1, known_rsp(ST_GOOD, 1, 0, 1, 3, 0));
		add_row(ACT_READ, 8'h00, 8'd0,   FILL_NONE, 1, known_rsp(ST_READ, 0, 8'hFF, 1, 3, 0));
		add_row(ACT_READ, 8'h00, 8'd1,   FILL_NONE, 1, known_rsp(ST_READ, 0, 0, 1, 3, 0));
		add_row(ACT_LINE, 8'h02, 8'd0,   FILL_NONE, 0, '0);
		add_row(ACT_LINE, 8'h00, 8'd0,   FILL_NONE, 0, '0);
		add_row(ACT_LINE, 8'h00, 8'd0,   FILL_NONE, 0, '0);
		add_row(ACT_READ, 8'h00, 8'd0,   FILL_NONE, 0, '0);
		add_row(ACT_LINE, 8'h80, 8'd0,   FILL_NONE, 0, '0);
		add_row(ACT_LINE, 8'h00, 8'd0,   FILL_CRC_LO, 0, '0);
		add_row(ACT_LINE, 8'h00, 8'd0,   FILL_CRC_BAD, 1, known_rsp(ST_CRC_ERR, 2, 0, 1, 3, 1));
		add_row(ACT_READ, 8'h00, 8'd0,   FILL_NONE, 0, '0);
		add_row(ACT_READ, 8'h00, 8'd1,   FILL_NONE, 1, known_rsp(ST_READ, 0, 0, 1, 3, 1));
		quiet_from = plan_rows.size() + RANDOM_ITEMS - QUIET_ITEMS;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan_rows[i]) begin
			rq = plan_rows[i].rq;
			if (plan_rows[i].fill != FILL_NONE) begin
				rq.line_byte = crc_byte_for(plan_rows[i].fill);
			end
			push_item(rq, plan_rows[i].typed, plan_rows[i].want);
		end

		while (items_sent < quiet_from + QUIET_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				if (frames == 0) begin
					len = MAX_PAYLOAD;
				end else if ($urandom_range(0, 39) == 0) begin
					len = $urandom_range(0, 1) ? MAX_PAYLOAD : MAX_PAYLOAD - 1;
				end else if ($urandom_range(0, 9) == 0) begin
					len = $urandom_range(13, 64);
				end else begin
					len = $urandom_range(1, 12);
				end
				random_frame(len);
				frames++;
			end else if (pick < 85) begin
				drive_read();
			end else if (pick < 93) begin
				case ($urandom_range(0, 3))
					0: begin
						drive_line(8'h00);
						drive_line(8'h00);
					end
					1: begin
						drive_line(8'($urandom_range(1, 255)));
						drive_line(8'h01);
					end
					default: begin
						drive_line(8'($urandom_range(0, 255)));
						drive_line(8'($urandom_range(2, 255)));
					end
				endcase
			end else begin
				drive_line(8'($urandom_range(0, 255)));
			end
		end
		req_valid <= 1'b0;

		while (rsp_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d items (%0d well-formed random frames), checked %0d responses.",
			items_sent, frames, rsp_checked);
		$display("Frames good %0d, crc errors %0d, length errors %0d.",
			good_cnt, crc_err_cnt, len_err_cnt);
		if (errors == 0) begin
			$display("crc16_length_frame_receiver: match");
		end else begin
			$display("crc16_length_frame_receiver: mismatch");
		end
		$finish;
	end

endmodule

FILE: sim.f
design/crclf_pkg.sv
design/crclf_payload_ram.sv
design/crclf_parser.sv
design/crc16_length_frame_receiver.sv
dv/crc16_length_frame_receiver_tb.sv
